@@ rtl/core/b64e_pkg.sv @@
package b64e_pkg;

  localparam logic [6:0] PAD_CODE = 7'h3D;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][6:0] codes;
    logic            final_msg;
  } job_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 7'h41 + {1'b0, v};
      [6'd26:6'd51]: c = 7'h61 + {1'b0, v} - 7'd26;
      [6'd52:6'd61]: c = 7'h30 + {1'b0, v} - 7'd52;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/b64e_front.sv @@
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output job_t       job
);

  phase_t     phase, phase_next;
  logic [3:0] left, left_next;

  // next state
  always_comb begin
    phase_next = phase;
    left_next  = left;
    if (take) begin
      case (phase)
        PH_SECOND: begin
          phase_next = PH_THIRD;
          left_next  = data_byte[3:0];
        end
        PH_THIRD: begin
          phase_next = PH_FIRST;
          left_next  = '0;
        end
        default: begin
          phase_next = PH_SECOND;
          left_next  = {2'b00, data_byte[1:0]};
        end
      endcase
      if (final_byte) begin
        phase_next = PH_FIRST;
        left_next  = '0;
      end
    end
  end

  // outputs: classify the byte into a character word group
  always_comb begin
    job.codes     = {4{PAD_CODE}};
    job.final_msg = final_byte;
    case (phase)
      PH_SECOND: begin
        job.codes[0] = sextet_char({left[1:0], data_byte[7:4]});
        job.codes[1] = sextet_char({data_byte[3:0], 2'b00});
        job.last_idx = final_byte ? 2'd2 : 2'd0;
      end
      PH_THIRD: begin
        job.codes[0] = sextet_char({left, data_byte[7:6]});
        job.codes[1] = sextet_char(data_byte[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        job.codes[0] = sextet_char(data_byte[7:2]);
        job.codes[1] = sextet_char({data_byte[1:0], 4'b0000});
        job.last_idx = final_byte ? 2'd3 : 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      left  <= '0;
    end else begin
      phase <= phase_next;
      left  <= left_next;
    end
  end

endmodule

@@ rtl/core/b64e_queue.sv @@
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  output logic full,
  input  logic rd,
  output job_t rd_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full   = (count == FULL_CNT);
  assign empty  = (count == '0);
  assign rd_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) !(wr && full && !rd))
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (rst) !(rd && empty))
    else $error("read from empty queue");

endmodule

@@ rtl/core/b64e_back.sv @@
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [6:0] char_code,
  output logic       final_char
);

  job_t       job;
  logic       busy;
  logic [1:0] idx;
  logic       at_last;

  assign at_last    = (idx == job.last_idx);
  assign q_rd       = !q_empty && (!busy || (pop && at_last));
  assign empty      = !busy;
  assign char_code  = job.codes[idx];
  assign final_char = job.final_msg && at_last;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_rd) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && pop) begin
      if (at_last) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> idx <= job.last_idx)
    else $error("character index past end of group");
  assert property (@(posedge clk) disable iff (rst) (busy && pop && !at_last) |=> busy)
    else $error("group dropped before last character");
  assert property (@(posedge clk) disable iff (rst) (!busy && !q_empty) |=> busy)
    else $error("waiting group not loaded");

endmodule

@@ rtl/core/base64_stream_encoder.sv @@
// Base64 encoder (standard alphabet, '=' padding). Push one message byte per
// word with final_byte set on the last one; pop one ASCII character per word,
// final_char marks the last character of the message. Each byte yields one
// to four characters and the single output port delivers one character per
// cycle while pop is held. A byte's group is written into the queue and then
// loaded into the output register before its first character is poppable.
// Bytes are classified on entry and up to QUEUE_DEPTH encoded groups wait
// behind the character being shifted out; full rises when they are all
// taken. Reset starts a new message.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] char_code,
  output logic       final_char
);

  job_t fr_job, q_job;
  logic take, q_rd, q_empty;

  assign take = push && !full;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .job        (fr_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (take),
    .wr_job (fr_job),
    .full   (full),
    .rd     (q_rd),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .char_code  (char_code),
    .final_char (final_char)
  );

endmodule
